[rtl/csq_pkg.sv]
package csq_pkg;

   localparam int DIM_MAX      = 8;
   localparam int ELEM_W       = 16;
   localparam int MAG_W        = 17;
   localparam int SQ_W         = 31;
   localparam int SUM_W        = 34;
   localparam int RAD_W        = 64;
   localparam int ROOT_W       = 32;
   localparam int ROOT_STEPS   = 32;
   localparam int RAD_SHIFT    = 30;
   localparam int PROD_W       = MAG_W + ROOT_W;
   localparam int REM_W        = PROD_W + 1;
   localparam int QUO_W        = 16;
   localparam int TREE_STAGES  = 3;
   localparam int LANE_STAGES  = 2;
   localparam int DEF_DIM      = 8;
   localparam int DEF_FRAC     = 12;

   // per-lane sideband carried alongside the length computation
   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } lane_side_type;

endpackage

[rtl/csq_if.sv]
interface csq_req_if;
   logic valid;
   logic ready;
   logic signed [csq_pkg::ELEM_W-1:0] elem_0;
   logic signed [csq_pkg::ELEM_W-1:0] elem_1;
   logic signed [csq_pkg::ELEM_W-1:0] elem_2;
   logic signed [csq_pkg::ELEM_W-1:0] elem_3;
   logic signed [csq_pkg::ELEM_W-1:0] elem_4;
   logic signed [csq_pkg::ELEM_W-1:0] elem_5;
   logic signed [csq_pkg::ELEM_W-1:0] elem_6;
   logic signed [csq_pkg::ELEM_W-1:0] elem_7;

   modport source (output valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
                   elem_7, input ready);
   modport sink (input valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
                 elem_7, output ready);
endinterface

interface csq_rsp_if;
   logic valid;
   logic ready;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_0;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_1;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_2;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_3;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_4;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_5;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_6;
   logic signed [csq_pkg::ELEM_W-1:0] squashed_7;

   modport source (output valid, squashed_0, squashed_1, squashed_2, squashed_3, squashed_4,
                   squashed_5, squashed_6, squashed_7, input ready);
   modport sink (input valid, squashed_0, squashed_1, squashed_2, squashed_3, squashed_4,
                 squashed_5, squashed_6, squashed_7, output ready);
endinterface

[rtl/capsule_vector_squash.sv]
// channel | dir | handshake     | payload
// req_if  | in  | valid / ready | elem_0 .. elem_7, signed Q4.12
// rsp_if  | out | valid / ready | squashed_0 .. squashed_7, signed Q1.15
//
// one capsule per cycle unless the output stalls; stages: 2 lane square, 3 sum tree,
// 32 square-root steps (one root bit each), 1 multiply, 16 divider steps, 1 sign
// synchronous active-high reset empties the pipeline; payload registers are not reset
// a stalled result freezes the whole pipeline; ready follows rsp ready or an empty output
module capsule_vector_squash #(
   parameter int VECTOR_DIM   = csq_pkg::DEF_DIM,
   parameter int IN_FRAC_BITS = csq_pkg::DEF_FRAC
) (
   input  logic        clock,
   input  logic        reset,
   csq_req_if.sink     req_if,
   csq_rsp_if.source   rsp_if
);

   localparam int DEPTH = csq_pkg::LANE_STAGES + csq_pkg::TREE_STAGES + csq_pkg::ROOT_STEPS
                          + 1 + csq_pkg::QUO_W + 1;
   localparam int SIDE_W = $bits(csq_pkg::lane_side_type);
   localparam int PAY_W  = csq_pkg::SUM_W + csq_pkg::DIM_MAX * SIDE_W;
   localparam logic [csq_pkg::SUM_W-1:0] DEN_ONE = csq_pkg::SUM_W'(1) << (2*IN_FRAC_BITS);

   logic                       adv;
   logic [DEPTH-1:0]           valid_ff, valid_in;
   logic [csq_pkg::ELEM_W-1:0] elem  [csq_pkg::DIM_MAX];
   logic [csq_pkg::ELEM_W-1:0] res   [csq_pkg::DIM_MAX];
   logic [csq_pkg::SQ_W-1:0]   sq    [csq_pkg::DIM_MAX];
   csq_pkg::lane_side_type     side  [csq_pkg::DIM_MAX];
   logic [csq_pkg::SUM_W-1:0]  l1_ff [4];
   logic [csq_pkg::SUM_W-1:0]  l2_ff [2];
   logic [csq_pkg::SUM_W-1:0]  l3_ff;
   logic [csq_pkg::DIM_MAX*SIDE_W-1:0] side_vec, t1_ff, t2_ff, t3_ff;
   logic [PAY_W-1:0]           pay_root;
   logic [csq_pkg::ROOT_W-1:0] root;
   logic [csq_pkg::SUM_W-1:0]  sum_root;
   csq_pkg::lane_side_type     side_root [csq_pkg::DIM_MAX];
   logic [csq_pkg::PROD_W-1:0] prod_ff [csq_pkg::DIM_MAX];
   logic                       neg_ff  [csq_pkg::DIM_MAX];
   logic [csq_pkg::SUM_W-1:0]  den_ff;

   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;

   assign elem[0] = req_if.elem_0;
   assign elem[1] = req_if.elem_1;
   assign elem[2] = req_if.elem_2;
   assign elem[3] = req_if.elem_3;
   assign elem[4] = req_if.elem_4;
   assign elem[5] = req_if.elem_5;
   assign elem[6] = req_if.elem_6;
   assign elem[7] = req_if.elem_7;

   for (genvar i = 0; i < csq_pkg::DIM_MAX; i++) begin : g_lane
      if (i < VECTOR_DIM) begin : g_used
         csq_lane u_lane (
            .clock (clock),
            .adv   (adv),
            .elem  (elem[i]),
            .sq    (sq[i]),
            .side  (side[i])
         );
      end else begin : g_unused
         assign sq[i]   = '0;
         assign side[i] = '0;
      end
      assign side_vec[i*SIDE_W +: SIDE_W] = side[i];
      assign side_root[i] = pay_root[i*SIDE_W +: SIDE_W];
   end

   // registered sum tree over the lane squares
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            l1_ff[k] <= csq_pkg::SUM_W'(sq[2*k]) + csq_pkg::SUM_W'(sq[2*k+1]);
         end
         l2_ff[0] <= l1_ff[0] + l1_ff[1];
         l2_ff[1] <= l1_ff[2] + l1_ff[3];
         l3_ff    <= l2_ff[0] + l2_ff[1];
         t1_ff    <= side_vec;
         t2_ff    <= t1_ff;
         t3_ff    <= t2_ff;
      end
   end

   csq_sqrt #(.PAY_W(PAY_W)) u_sqrt (
      .clock (clock),
      .adv   (adv),
      .rad   (csq_pkg::RAD_W'(l3_ff) << csq_pkg::RAD_SHIFT),
      .pay_i ({l3_ff, t3_ff}),
      .root  (root),
      .pay_o (pay_root)
   );

   assign sum_root = pay_root[PAY_W-1 -: csq_pkg::SUM_W];

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff <= DEN_ONE + sum_root;
         for (int k = 0; k < csq_pkg::DIM_MAX; k++) begin
            prod_ff[k] <= side_root[k].mag * root;
            neg_ff[k]  <= side_root[k].neg;
         end
      end
   end

   for (genvar i = 0; i < csq_pkg::DIM_MAX; i++) begin : g_div
      if (i < VECTOR_DIM) begin : g_used
         csq_div u_div (
            .clock (clock),
            .adv   (adv),
            .num   (prod_ff[i]),
            .den   (den_ff),
            .neg   (neg_ff[i]),
            .res   (res[i])
         );
      end else begin : g_unused
         assign res[i] = '0;
      end
   end

   assign valid_in = adv ? {valid_ff[DEPTH-2:0], req_if.valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_if.valid      = valid_ff[DEPTH-1];
   assign rsp_if.squashed_0 = res[0];
   assign rsp_if.squashed_1 = res[1];
   assign rsp_if.squashed_2 = res[2];
   assign rsp_if.squashed_3 = res[3];
   assign rsp_if.squashed_4 = res[4];
   assign rsp_if.squashed_5 = res[5];
   assign rsp_if.squashed_6 = res[6];
   assign rsp_if.squashed_7 = res[7];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> valid_ff[0])
      else $error("accepted capsule missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved during output stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_stall_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("transfer accepted while pipeline frozen");

endmodule

[rtl/csq_lane.sv]
module csq_lane (
   input  logic                               clock,
   input  logic                               adv,
   input  logic [csq_pkg::ELEM_W-1:0]         elem,
   output logic [csq_pkg::SQ_W-1:0]           sq,
   output csq_pkg::lane_side_type             side
);

   csq_pkg::lane_side_type          side0_ff, side0_in;
   csq_pkg::lane_side_type          side1_ff;
   logic [csq_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic [2*csq_pkg::MAG_W-1:0]     prod;

   always_comb begin
      side0_in.neg = elem[csq_pkg::ELEM_W-1];
      // most negative code keeps its full magnitude
      side0_in.mag = elem[csq_pkg::ELEM_W-1] ?
                     (csq_pkg::MAG_W'(0) - {1'b1, elem}) : {1'b0, elem};
   end

   assign prod  = side0_ff.mag * side0_ff.mag;
   assign sq_in = prod[csq_pkg::SQ_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         side0_ff <= side0_in;
         side1_ff <= side0_ff;
         sq_ff    <= sq_in;
      end
   end

   assign sq   = sq_ff;
   assign side = side1_ff;

endmodule

[rtl/csq_sqrt.sv]
module csq_sqrt #(
   parameter int PAY_W = 8
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [csq_pkg::RAD_W-1:0]     rad,
   input  logic [PAY_W-1:0]              pay_i,
   output logic [csq_pkg::ROOT_W-1:0]    root,
   output logic [PAY_W-1:0]              pay_o
);

   localparam int N = csq_pkg::ROOT_STEPS;

   logic [csq_pkg::RAD_W-1:0] rem_ff  [N];
   logic [csq_pkg::RAD_W-1:0] root_ff [N];
   logic [PAY_W-1:0]          pay_ff  [N];

   // one result bit per stage, restoring digit recurrence
   for (genvar j = 0; j < N; j++) begin : g_step
      localparam logic [csq_pkg::RAD_W-1:0] BIT =
         csq_pkg::RAD_W'(1) << (csq_pkg::RAD_W - 2 - 2*j);
      logic [csq_pkg::RAD_W-1:0] rem_prev, root_prev, trial, rem_in, root_in;
      logic [PAY_W-1:0]          pay_prev;

      if (j == 0) begin : g_first
         assign rem_prev  = rad;
         assign root_prev = '0;
         assign pay_prev  = pay_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign pay_prev  = pay_ff[j-1];
      end

      always_comb begin
         trial = root_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            pay_ff[j]  <= pay_prev;
         end
      end
   end

   assign root  = root_ff[N-1][csq_pkg::ROOT_W-1:0];
   assign pay_o = pay_ff[N-1];

endmodule

[rtl/csq_div.sv]
module csq_div (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [csq_pkg::PROD_W-1:0]    num,
   input  logic [csq_pkg::SUM_W-1:0]     den,
   input  logic                          neg,
   output logic [csq_pkg::ELEM_W-1:0]    res
);

   localparam int N = csq_pkg::QUO_W;

   logic [csq_pkg::REM_W-1:0] rem_ff [N];
   logic [csq_pkg::SUM_W-1:0] den_ff [N];
   logic [N-1:0]              quo_ff [N];
   logic                      neg_ff [N];
   logic [csq_pkg::ELEM_W-1:0] res_ff, res_in;

   // quotient stays below one in Q1.15, so sixteen bits cover it
   for (genvar s = 0; s < N; s++) begin : g_step
      localparam int K = N - 1 - s;
      logic [csq_pkg::REM_W-1:0] rem_prev, dsh, rem_in;
      logic [csq_pkg::SUM_W-1:0] den_prev;
      logic [N-1:0]              quo_prev, quo_in;
      logic                      neg_prev;

      if (s == 0) begin : g_first
         assign rem_prev = {1'b0, num};
         assign den_prev = den;
         assign quo_prev = '0;
         assign neg_prev = neg;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign den_prev = den_ff[s-1];
         assign quo_prev = quo_ff[s-1];
         assign neg_prev = neg_ff[s-1];
      end

      always_comb begin
         dsh    = csq_pkg::REM_W'(den_prev) << K;
         quo_in = quo_prev;
         rem_in = rem_prev;
         if (rem_prev >= dsh) begin
            rem_in    = rem_prev - dsh;
            quo_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_prev;
            quo_ff[s] <= quo_in;
            neg_ff[s] <= neg_prev;
         end
      end
   end

   assign res_in = neg_ff[N-1] ? (csq_pkg::ELEM_W'(0) - quo_ff[N-1]) : quo_ff[N-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
